// ===== hw/rtl/hfcc_pkg.sv =====
// Package for the half-float classify/compare block: field widths, class bit
// positions and the class mask function. No dependencies.
package hfcc_pkg;

   localparam int ValueWidth = 16;
   localparam int ClassWidth = 14;

   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [ClassWidth-1:0] class_type;

   typedef struct packed {
      value_type left_half;
      value_type right_half;
   } req_type;

   typedef struct packed {
      class_type   left_class;
      class_type   right_class;
      logic [1:0]  total_order;
      logic        same_value;
      logic        op_equal;
      logic        op_less;
      logic        op_less_equal;
      logic        op_greater;
      logic        op_greater_equal;
   } rsp_type;

   localparam logic [1:0] OrderEqual   = 2'b00;
   localparam logic [1:0] OrderGreater = 2'b01;
   localparam logic [1:0] OrderLess    = 2'b11;

   localparam logic [4:0] ExpAllOnes = 5'h1F;
   localparam logic [4:0] ExpBias    = 5'd15;

   // Class mask of one binary16 pattern.
   function automatic class_type half_class(input value_type v);
      logic [4:0]  expo;
      logic [9:0]  man;
      logic        neg, finite, nan, inf, zero, normal, subn;
      logic        isint, even, pow2;
      logic [4:0]  u;
      logic [10:0] sig;
      logic [10:0] fracmask;
      logic [10:0] shifted;
      logic [3:0]  sh;
      class_type   r;
      expo   = v[14:10];
      man    = v[9:0];
      neg    = v[15];
      finite = expo != ExpAllOnes;
      nan    = !finite && man != '0;
      inf    = !finite && man == '0;
      zero   = v[14:0] == '0;
      normal = finite && expo != '0;
      subn   = expo == '0 && man != '0;
      u      = expo - ExpBias;
      sig    = {1'b1, man};
      sh     = 4'd10 - u[3:0];
      fracmask = (11'd1 << sh) - 11'd1;
      shifted  = sig >> sh;
      isint = 1'b0;
      even  = 1'b0;
      if (zero) begin
         isint = 1'b1;
         even  = 1'b1;
      end else if (normal && expo >= ExpBias) begin
         if (u >= 5'd10) begin
            isint = 1'b1;
            even  = (u >= 5'd11) || !sig[0];
         end else begin
            isint = (sig & fracmask) == '0;
            even  = !shifted[0];
         end
      end
      pow2 = !neg && ((normal && man == '0) ||
                      (subn && (man & (man - 10'd1)) == '0));
      r = '0;
      r[0]  = finite;
      r[1]  = nan;
      r[2]  = inf;
      r[3]  = inf && !neg;
      r[4]  = inf && neg;
      r[5]  = normal;
      r[6]  = subn;
      r[7]  = zero;
      r[8]  = neg;
      r[9]  = isint;
      r[10] = isint && even;
      r[11] = isint && !even;
      r[12] = pow2;
      r[13] = nan || zero;
      return r;
   endfunction

endpackage

// ===== hw/rtl/hfcc_if.sv =====
// Valid/ready channel carrying one payload struct.
// The payload type is a parameter; it does not depend on hfcc_pkg.
interface hfcc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/hfcc_compare.sv =====
// Comparison logic for two binary16 patterns: total order, same value and
// the IEEE relations. Depends on hfcc_pkg.
module hfcc_compare (
   input  hfcc_pkg::value_type left_half,
   input  hfcc_pkg::value_type right_half,
   output logic [1:0]          total_order,
   output logic                same_value,
   output logic                op_equal,
   output logic                op_less,
   output logic                op_greater
);
   import hfcc_pkg::*;

   logic        an, bn, anyn, both_zero;
   logic signed [15:0] ka, kb;
   logic        lt, gt, eq;

   assign an = left_half[14:10] == ExpAllOnes && left_half[9:0] != '0;
   assign bn = right_half[14:10] == ExpAllOnes && right_half[9:0] != '0;
   assign anyn = an || bn;
   assign both_zero = (left_half[14:0] | right_half[14:0]) == '0;
   // signed-magnitude to ordered key; both zeros map to 0
   assign ka = left_half[15] ? -$signed({1'b0, left_half[14:0]})
                             : $signed({1'b0, left_half[14:0]});
   assign kb = right_half[15] ? -$signed({1'b0, right_half[14:0]})
                              : $signed({1'b0, right_half[14:0]});
   assign lt = ka < kb;
   assign gt = ka > kb;
   assign eq = ka == kb;

   always_comb begin
      if (an && bn)  total_order = OrderEqual;
      else if (an)   total_order = OrderLess;
      else if (bn)   total_order = OrderGreater;
      else if (lt)   total_order = OrderLess;
      else if (gt)   total_order = OrderGreater;
      else           total_order = OrderEqual;
   end

   assign same_value = left_half == right_half || both_zero || (an && bn);
   assign op_equal   = !anyn && eq;
   assign op_less    = !anyn && lt;
   assign op_greater = !anyn && gt;
endmodule

// ===== hw/rtl/half_float_classify_compare.sv =====
// Top level: binary16 classify and compare with registered input and output.
// Depends on hfcc_pkg, hfcc_if and hfcc_compare.
//
//   channel | ports | direction | payload
//   req     | req   | sink      | left_half, right_half
//   rsp     | rsp   | source    | left_class .. op_greater_equal
//
// From req to rsp each transaction passes an input register, then the class
// and compare logic into the result register. One transaction per cycle is
// sustained while rsp is ready. Stages advance when the next one is empty or
// being drained, so a stalled rsp holds both stages. Reset clears valid bits.
module half_float_classify_compare (
   input logic clock,
   input logic reset,
   hfcc_if.sink   req,
   hfcc_if.source rsp
);
   import hfcc_pkg::*;

   logic       in_vld_ff, in_vld_in;
   req_type    in_data_ff;
   logic       out_vld_ff, out_vld_in;
   rsp_type    out_data_ff, out_data_in;
   logic       out_adv, in_adv;
   logic [1:0] order;
   logic       same, eq, lt, gt;

   assign out_adv = !out_vld_ff || rsp.ready;
   assign in_adv  = !in_vld_ff || out_adv;
   assign req.ready = in_adv;

   assign in_vld_in  = in_adv ? req.valid : in_vld_ff;
   assign out_vld_in = out_adv ? in_vld_ff : out_vld_ff;

   hfcc_compare u_cmp (
      .left_half   (in_data_ff.left_half),
      .right_half  (in_data_ff.right_half),
      .total_order (order),
      .same_value  (same),
      .op_equal    (eq),
      .op_less     (lt),
      .op_greater  (gt)
   );

   always_comb begin
      out_data_in.left_class       = half_class(in_data_ff.left_half);
      out_data_in.right_class      = half_class(in_data_ff.right_half);
      out_data_in.total_order      = order;
      out_data_in.same_value       = same;
      out_data_in.op_equal         = eq;
      out_data_in.op_less          = lt;
      out_data_in.op_greater       = gt;
      out_data_in.op_less_equal    = lt || eq;
      out_data_in.op_greater_equal = gt || eq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (in_adv && req.valid) in_data_ff <= req.payload;
      if (out_adv && in_vld_ff) out_data_ff <= out_data_in;
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_data_ff;
endmodule
